@@ rtl/lbsc_pkg.sv @@
// Shared constants, types and the CRC-8 byte update for the lamp brightness command slave.
`timescale 1ns / 1ps

package lbsc_pkg;

    // Command bytes and CRC polynomial (Dallas CRC-8, reflected)
    localparam logic [7:0]  CMD_SET    = 8'h63;
    localparam logic [7:0]  CMD_READ   = 8'h6C;
    localparam logic [7:0]  CRC_POLY   = 8'h8C;

    // Reset values
    localparam logic [7:0]  RESET_LEVEL   = 8'd100;
    localparam logic [15:0] RESET_TIMEOUT = 16'd900;
    localparam logic [7:0]  RESET_HOLD    = 8'd20;
    localparam logic [9:0]  RESET_TPS     = 10'd1000;

    // Bits in one serial byte
    localparam logic [3:0]  BYTE_BITS = 4'd8;

    // Configuration port
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS     = 2'd2;

    // Command phase of the serial slave
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SET_LEVEL = 3'd1,
        PH_SET_DFLT  = 3'd2,
        PH_SET_CRC   = 3'd3,
        PH_RD_LEVEL  = 3'd4,
        PH_RD_DFLT   = 3'd5,
        PH_RD_CRC    = 3'd6
    } phase_t;

    // Sampled pins of one tick
    typedef struct packed {
        logic lamp_off;
        logic select;
        logic clock;
        logic data;
    } pins_t;

    // Accepted set command, handed from the serial slave to the lamp control
    typedef struct packed {
        logic       apply;
        logic [7:0] level;
        logic [7:0] dflt;
    } set_cmd_t;

    // One byte through the reflected CRC-8
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/lamp_brightness_spi_command_slave_unit.sv @@
// Top level of the lamp brightness controller with serial command slave.
//
//   channel | direction | beat contents
//   s_      | in        | lamp_off_pin, select_pin, clock_pin, data_pin (one 1 ms tick)
//   m_      | out       | drive_level, miso_level, brightness_updated, default_changed,
//           |           | current_brightness, default_brightness
//   cfg_    | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// One beat per clock sustained while m_ready holds; a tick is taken into the input register
// and shows on m_ when the state update loads the result register.
// The tick's whole update, including up to two CRC-8 byte steps, is one combinational pass.
// Reset is synchronous: levels return to 100, counters and the command phase clear.
// A stall on m_ holds the result register; s_ready drops once the input register is also full.
`timescale 1ns / 1ps

module lamp_brightness_spi_command_slave_unit
    import lbsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_lamp_off_pin,
    input  logic                  s_select_pin,
    input  logic                  s_clock_pin,
    input  logic                  s_data_pin,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_drive_level,
    output logic                  m_miso_level,
    output logic                  m_brightness_updated,
    output logic                  m_default_changed,
    output logic [7:0]            m_current_brightness,
    output logic [7:0]            m_default_brightness
);

    logic       in_vld_reg;
    pins_t      pins_reg;
    logic       out_vld_reg;
    logic       advance;

    set_cmd_t   set_cmd;
    logic [7:0] cur_mid, dflt_level;
    logic [7:0] drive_next, cur_next, dflt_next;
    logic       dflt_changed, miso_next;

    logic [7:0] drive_out_reg, cur_out_reg, dflt_out_reg;
    logic       miso_out_reg, upd_out_reg, chg_out_reg;

    // Process the held tick when the result register is free
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pins_reg <= '{lamp_off: s_lamp_off_pin, select: s_select_pin,
                          clock: s_clock_pin, data: s_data_pin};
        end
    end

    lbsc_serial u_serial (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .pins       (pins_reg),
        .cur_level  (cur_mid),
        .dflt_level (dflt_level),
        .miso_next  (miso_next),
        .set_cmd    (set_cmd)
    );

    lbsc_lamp u_lamp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .advance      (advance),
        .lamp_off     (pins_reg.lamp_off),
        .set_cmd      (set_cmd),
        .cur_mid      (cur_mid),
        .dflt_level   (dflt_level),
        .drive_next   (drive_next),
        .cur_next     (cur_next),
        .dflt_next    (dflt_next),
        .dflt_changed (dflt_changed)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_out_reg <= drive_next;
            miso_out_reg  <= miso_next;
            upd_out_reg   <= set_cmd.apply;
            chg_out_reg   <= dflt_changed;
            cur_out_reg   <= cur_next;
            dflt_out_reg  <= dflt_next;
        end
    end

    assign m_valid              = out_vld_reg;
    assign m_drive_level        = drive_out_reg;
    assign m_miso_level         = miso_out_reg;
    assign m_brightness_updated = upd_out_reg;
    assign m_default_changed    = chg_out_reg;
    assign m_current_brightness = cur_out_reg;
    assign m_default_brightness = dflt_out_reg;

endmodule

@@ rtl/lbsc_serial.sv @@
// Bit-banged serial command slave: byte shifter, command phase machine and CRC check.
`timescale 1ns / 1ps

module lbsc_serial
    import lbsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  pins_t      pins,
    input  logic [7:0] cur_level,
    input  logic [7:0] dflt_level,
    output logic       miso_next,
    output set_cmd_t   set_cmd
);

    logic       select_active_reg, select_active_next;
    logic       clock_seen_reg, clock_seen_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic [7:0] shift_reg, shift_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] pend_level_reg, pend_level_next;
    logic [7:0] pend_dflt_reg, pend_dflt_next;
    logic       miso_reg;

    // Advance the slave by one tick
    always_comb begin
        logic [3:0] bits_dec;
        logic [7:0] rx_byte;
        logic [7:0] crc_tmp;
        select_active_next = select_active_reg;
        clock_seen_next    = clock_seen_reg;
        bits_left_next     = bits_left_reg;
        shift_next         = shift_reg;
        phase_next         = phase_reg;
        crc_next           = crc_reg;
        pend_level_next    = pend_level_reg;
        pend_dflt_next     = pend_dflt_reg;
        miso_next          = miso_reg;
        set_cmd            = '0;
        bits_dec           = 4'd0;
        rx_byte            = 8'd0;
        crc_tmp            = 8'd0;

        if (pins.select) begin
            // Deselect drops the command
            select_active_next = 1'b0;
            phase_next         = PH_IDLE;
        end else begin
            // Restart byte framing on a fresh select
            if (!select_active_reg) begin
                select_active_next = 1'b1;
                bits_left_next     = BYTE_BITS;
                shift_next         = 8'd0;
            end
            if (pins.clock) begin
                clock_seen_next = 1'b1;
            end else begin
                if (clock_seen_reg) begin
                    // Falling edge: drive out LSB, shift in inverted data
                    miso_next  = shift_next[0];
                    shift_next = {~pins.data, shift_next[7:1]};
                    bits_dec   = bits_left_next - 4'd1;
                    bits_left_next = bits_dec;
                    if (bits_dec == 4'd0) begin
                        bits_left_next = BYTE_BITS;
                        rx_byte        = shift_next;
                        unique case (phase_reg)
                            PH_IDLE: begin
                                crc_tmp  = crc8_step(8'd0, rx_byte);
                                crc_next = crc_tmp;
                                if (rx_byte == CMD_SET) begin
                                    phase_next = PH_SET_LEVEL;
                                end else if (rx_byte == CMD_READ) begin
                                    shift_next = cur_level;
                                    crc_next   = crc8_step(crc_tmp, cur_level);
                                    phase_next = PH_RD_LEVEL;
                                end
                            end
                            PH_SET_LEVEL: begin
                                pend_level_next = rx_byte;
                                crc_next        = crc8_step(crc_reg, rx_byte);
                                phase_next      = PH_SET_DFLT;
                            end
                            PH_SET_DFLT: begin
                                pend_dflt_next = rx_byte;
                                crc_next       = crc8_step(crc_reg, rx_byte);
                                phase_next     = PH_SET_CRC;
                            end
                            PH_SET_CRC: begin
                                crc_tmp  = crc8_step(crc_reg, rx_byte);
                                crc_next = crc_tmp;
                                if (crc_tmp == 8'd0) begin
                                    set_cmd.apply = 1'b1;
                                    set_cmd.level = pend_level_reg;
                                    set_cmd.dflt  = pend_dflt_reg;
                                end
                                phase_next = PH_IDLE;
                            end
                            PH_RD_LEVEL: begin
                                shift_next = dflt_level;
                                crc_next   = crc8_step(crc_reg, dflt_level);
                                phase_next = PH_RD_DFLT;
                            end
                            PH_RD_DFLT: begin
                                shift_next = crc_reg;
                                phase_next = PH_RD_CRC;
                            end
                            default: begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                clock_seen_next = 1'b0;
            end
        end
    end

    // Hold state between accepted beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_active_reg <= 1'b0;
            clock_seen_reg    <= 1'b0;
            bits_left_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            phase_reg         <= PH_IDLE;
            crc_reg           <= 8'd0;
            pend_level_reg    <= 8'd0;
            pend_dflt_reg     <= 8'd0;
            miso_reg          <= 1'b0;
        end else if (advance) begin
            select_active_reg <= select_active_next;
            clock_seen_reg    <= clock_seen_next;
            bits_left_reg     <= bits_left_next;
            shift_reg         <= shift_next;
            phase_reg         <= phase_next;
            crc_reg           <= crc_next;
            pend_level_reg    <= pend_level_next;
            pend_dflt_reg     <= pend_dflt_next;
            miso_reg          <= miso_next;
        end
    end

endmodule

@@ rtl/lbsc_lamp.sv @@
// Lamp drive with hold-off, brightness levels, timeout counters and configuration registers.
`timescale 1ns / 1ps

module lbsc_lamp
    import lbsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  advance,
    input  logic                  lamp_off,
    input  set_cmd_t              set_cmd,
    output logic [7:0]            cur_mid,
    output logic [7:0]            dflt_level,
    output logic [7:0]            drive_next,
    output logic [7:0]            cur_next,
    output logic [7:0]            dflt_next,
    output logic                  dflt_changed
);

    logic [15:0] timeout_reg;
    logic [7:0]  hold_cfg_reg;
    logic [9:0]  tps_reg;

    logic [7:0]  cur_reg, dflt_reg, hold_reg, hold_next, drive_reg;
    logic [9:0]  tick_reg, tick_next;
    logic [15:0] sec_reg, sec_next;

    logic [10:0] tick_sum;
    logic [16:0] sec_sum;
    logic        tick_roll, sec_roll;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= RESET_TIMEOUT;
            hold_cfg_reg <= RESET_HOLD;
            tps_reg      <= RESET_TPS;
        end else if (cfg_we) begin
            if (cfg_index == CFG_TIMEOUT) begin
                timeout_reg <= cfg_wdata;
            end else if (cfg_index == CFG_HOLD) begin
                hold_cfg_reg <= cfg_wdata[7:0];
            end else if (cfg_index == CFG_TPS) begin
                tps_reg <= cfg_wdata[9:0];
            end
        end
    end

    // Drive level follows the current level, held off after the request drops
    always_comb begin
        drive_next = drive_reg;
        hold_next  = hold_reg;
        if (lamp_off) begin
            if (hold_reg != 8'd0) begin
                hold_next = hold_reg - 8'd1;
            end else begin
                drive_next = 8'd0;
            end
        end else begin
            drive_next = cur_reg;
            hold_next  = hold_cfg_reg;
        end
    end

    // Tick and second counters; roll over at or past the limit
    assign tick_sum  = {1'b0, tick_reg} + 11'd1;
    assign tick_roll = (tick_sum >= {1'b0, tps_reg});
    assign sec_sum   = {1'b0, sec_reg} + 17'd1;
    assign sec_roll  = tick_roll && (sec_sum >= {1'b0, timeout_reg});
    assign tick_next = tick_roll ? 10'd0 : tick_sum[9:0];

    always_comb begin
        if (set_cmd.apply || sec_roll) begin
            sec_next = 16'd0;
        end else if (tick_roll) begin
            sec_next = sec_sum[15:0];
        end else begin
            sec_next = sec_reg;
        end
    end

    // Levels: timeout falls back to default, then an accepted set overrides
    assign cur_mid      = sec_roll ? dflt_reg : cur_reg;
    assign cur_next     = set_cmd.apply ? set_cmd.level : cur_mid;
    assign dflt_changed = set_cmd.apply && (set_cmd.dflt != dflt_reg);
    assign dflt_next    = dflt_changed ? set_cmd.dflt : dflt_reg;
    assign dflt_level   = dflt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= RESET_LEVEL;
            dflt_reg  <= RESET_LEVEL;
            hold_reg  <= 8'd0;
            drive_reg <= 8'd0;
            tick_reg  <= 10'd0;
            sec_reg   <= 16'd0;
        end else if (advance) begin
            cur_reg   <= cur_next;
            dflt_reg  <= dflt_next;
            hold_reg  <= hold_next;
            drive_reg <= drive_next;
            tick_reg  <= tick_next;
            sec_reg   <= sec_next;
        end
    end

endmodule

@@ rtl/lbsc_checker.sv @@
// Port-level checker for the lamp brightness command slave, bound to the top level.
`timescale 1ns / 1ps

module lbsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_drive_level,
    input logic       m_brightness_updated,
    input logic       m_default_changed,
    input logic [7:0] m_default_brightness
);

    logic       have_last_reg;
    logic [7:0] last_dflt_reg;

    // Track the default level of the last delivered beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_last_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            have_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            last_dflt_reg <= m_default_brightness;
        end
    end

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_level)
            && $stable(m_default_brightness))
        else $error("result changed while stalled");

    // A default change only comes with an accepted set
    a_change_needs_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_default_changed |-> m_brightness_updated)
        else $error("default_changed without brightness_updated");

    // Default level moves only on a flagged change
    a_dflt_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && have_last_reg && !m_default_changed
            |-> m_default_brightness == last_dflt_reg)
        else $error("default brightness moved without default_changed");

    // A flagged change really differs from the previous default
    a_dflt_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && have_last_reg && m_default_changed
            |-> m_default_brightness != last_dflt_reg)
        else $error("default_changed with unchanged default brightness");

endmodule

bind lamp_brightness_spi_command_slave_unit lbsc_checker u_lbsc_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_drive_level        (m_drive_level),
    .m_brightness_updated (m_brightness_updated),
    .m_default_changed    (m_default_changed),
    .m_default_brightness (m_default_brightness)
);

@@ sim/tb_lamp_brightness_spi_command_slave_unit.sv @@
// Self-checking testbench for the lamp brightness controller with serial command slave.
`timescale 1ns / 1ps

module tb_lamp_brightness_spi_command_slave_unit;
    import lbsc_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SEND_IDLE_PCT  = 31;
    localparam int         RECV_IDLE_PCT  = 31;
    localparam int         RANDOM_PHASES  = 2;
    localparam int         PHASE_TICKS    = 20;
    localparam logic [7:0] BOGUS_CMD      = 8'hA5;

    // One expected result beat
    typedef struct packed {
        logic [7:0] drive;
        logic       miso;
        logic       updated;
        logic       changed;
        logic [7:0] cur;
        logic [7:0] dflt;
    } lamp_tick_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_lamp_off_pin;
    logic                  s_select_pin;
    logic                  s_clock_pin;
    logic                  s_data_pin;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_drive_level;
    logic                  m_miso_level;
    logic                  m_brightness_updated;
    logic                  m_default_changed;
    logic [7:0]            m_current_brightness;
    logic [7:0]            m_default_brightness;

    // Predictor configuration and state
    logic [15:0] lim_seconds;
    logic [7:0]  lim_hold;
    logic [9:0]  lim_tps;
    logic [7:0]  cur_lvl, dflt_lvl, hold_cnt, drive_lvl;
    logic [9:0]  tick_cnt;
    logic [15:0] sec_cnt;
    logic        sel_on, sclk_high, miso_q;
    logic [3:0]  bits_to_go;
    logic [7:0]  shreg, crc_acc, new_lvl, new_dflt;
    phase_t      cmd_phase;

    lamp_tick_t  lamp_ticks_due[$];
    lamp_tick_t  due;

    // Stimulus control
    logic idle_en;
    logic lamp_off_now;
    int   lamp_flip_pct;
    int   rx_hold_req;

    int errors         = 0;
    int ticks_sent     = 0;
    int sets_applied   = 0;
    int dflt_changes   = 0;
    int reverts        = 0;
    int set_frames     = 0;
    int bad_frames     = 0;
    int read_frames    = 0;
    int odd_frames     = 0;

    lamp_brightness_spi_command_slave_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_lamp_off_pin       (s_lamp_off_pin),
        .s_select_pin         (s_select_pin),
        .s_clock_pin          (s_clock_pin),
        .s_data_pin           (s_data_pin),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_drive_level        (m_drive_level),
        .m_miso_level         (m_miso_level),
        .m_brightness_updated (m_brightness_updated),
        .m_default_changed    (m_default_changed),
        .m_current_brightness (m_current_brightness),
        .m_default_brightness (m_default_brightness)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Dallas CRC-8, one data bit at a time
    function automatic logic [7:0] crc8_dow(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ data[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Advance the predictor by one tick and return the beat it should produce
    function automatic lamp_tick_t advance_lamp(input logic lo, input logic sel,
                                                input logic sclk, input logic dat);
        lamp_tick_t r;
        logic [7:0] b;
        int         t;
        int         s;
        r.updated = 1'b0;
        r.changed = 1'b0;

        // lamp drive with hold-off
        if (lo) begin
            if (hold_cnt != 8'd0) begin
                hold_cnt = hold_cnt - 8'd1;
            end else begin
                drive_lvl = 8'd0;
            end
        end else begin
            drive_lvl = cur_lvl;
            hold_cnt  = lim_hold;
        end

        // tick and second counting, fall back to default on timeout
        t = int'(tick_cnt) + 1;
        if (t >= int'(lim_tps)) begin
            t = 0;
            s = int'(sec_cnt) + 1;
            if (s >= int'(lim_seconds)) begin
                cur_lvl = dflt_lvl;
                s = 0;
                reverts++;
            end
            sec_cnt = s[15:0];
        end
        tick_cnt = t[9:0];

        // serial slave: shift on a falling clock while selected
        if (sel) begin
            sel_on    = 1'b0;
            cmd_phase = PH_IDLE;
        end else begin
            if (!sel_on) begin
                sel_on     = 1'b1;
                bits_to_go = BYTE_BITS;
                shreg      = 8'h00;
            end
            if (sclk) begin
                sclk_high = 1'b1;
            end else begin
                if (sclk_high) begin
                    miso_q     = shreg[0];
                    shreg      = {~dat, shreg[7:1]};
                    bits_to_go = bits_to_go - 4'd1;
                    if (bits_to_go == 4'd0) begin
                        bits_to_go = BYTE_BITS;
                        b = shreg;
                        case (cmd_phase)
                            PH_IDLE: begin
                                crc_acc = crc8_dow(8'h00, b);
                                if (b == CMD_SET) begin
                                    cmd_phase = PH_SET_LEVEL;
                                end else if (b == CMD_READ) begin
                                    shreg     = cur_lvl;
                                    crc_acc   = crc8_dow(crc_acc, shreg);
                                    cmd_phase = PH_RD_LEVEL;
                                end
                            end
                            PH_SET_LEVEL: begin
                                new_lvl   = b;
                                crc_acc   = crc8_dow(crc_acc, b);
                                cmd_phase = PH_SET_DFLT;
                            end
                            PH_SET_DFLT: begin
                                new_dflt  = b;
                                crc_acc   = crc8_dow(crc_acc, b);
                                cmd_phase = PH_SET_CRC;
                            end
                            PH_SET_CRC: begin
                                crc_acc = crc8_dow(crc_acc, b);
                                if (crc_acc == 8'h00) begin
                                    sec_cnt   = 16'd0;
                                    cur_lvl   = new_lvl;
                                    r.updated = 1'b1;
                                    sets_applied++;
                                    if (dflt_lvl != new_dflt) begin
                                        dflt_lvl  = new_dflt;
                                        r.changed = 1'b1;
                                        dflt_changes++;
                                    end
                                end
                                cmd_phase = PH_IDLE;
                            end
                            PH_RD_LEVEL: begin
                                shreg     = dflt_lvl;
                                crc_acc   = crc8_dow(crc_acc, shreg);
                                cmd_phase = PH_RD_DFLT;
                            end
                            PH_RD_DFLT: begin
                                shreg     = crc_acc;
                                cmd_phase = PH_RD_CRC;
                            end
                            default: begin
                                cmd_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                sclk_high = 1'b0;
            end
        end

        r.drive = drive_lvl;
        r.miso  = miso_q;
        r.cur   = cur_lvl;
        r.dflt  = dflt_lvl;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Check each result beat against the oldest expectation, then predict the new tick
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (lamp_ticks_due.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with no tick outstanding", $time);
                end else begin
                    due = lamp_ticks_due.pop_front();
                    check_field("drive_level", due.drive, m_drive_level);
                    check_field("miso_level", {7'd0, due.miso}, {7'd0, m_miso_level});
                    check_field("brightness_updated", {7'd0, due.updated},
                                {7'd0, m_brightness_updated});
                    check_field("default_changed", {7'd0, due.changed},
                                {7'd0, m_default_changed});
                    check_field("current_brightness", due.cur, m_current_brightness);
                    check_field("default_brightness", due.dflt, m_default_brightness);
                end
            end
            if (s_valid && s_ready) begin
                lamp_ticks_due.push_back(advance_lamp(s_lamp_off_pin, s_select_pin,
                                                      s_clock_pin, s_data_pin));
                ticks_sent++;
            end
        end
    end

    // Result side: honor a requested hold-off, otherwise stall at random
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                m_ready <= 1'b0;
                rx_hold_req--;
            end else if (idle_en) begin
                m_ready <= ($urandom_range(99, 0) >= RECV_IDLE_PCT);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("tb_lamp_brightness_spi_command_slave_unit: done, errors");
        $finish;
    end

    // Offer one tick, possibly after random idle cycles, and hold it until accepted
    task automatic send_tick(input logic lo, input logic sel, input logic sclk, input logic dat);
        while (idle_en && $urandom_range(99, 0) < SEND_IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_lamp_off_pin <= lo;
        s_select_pin   <= sel;
        s_clock_pin    <= sclk;
        s_data_pin     <= dat;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Serial tick with the lamp request toggling now and then
    task automatic serial_tick(input logic sel, input logic sclk, input logic dat);
        if ($urandom_range(99, 0) < lamp_flip_pct) begin
            lamp_off_now = ~lamp_off_now;
        end
        send_tick(lamp_off_now, sel, sclk, dat);
    endtask

    // Shift one byte LSB first, data pin inverted, bit taken on the falling clock
    task automatic send_byte(input logic [7:0] val);
        for (int i = 0; i < 8; i++) begin
            serial_tick(1'b0, 1'b1, 1'($urandom_range(1, 0)));
            serial_tick(1'b0, 1'b0, ~val[i]);
        end
    endtask

    // Select with the clock high, shift n bytes (byte 0 in the low bits), deselect
    task automatic send_frame(input int n, input logic [31:0] frame_bytes);
        serial_tick(1'b0, 1'b1, 1'($urandom_range(1, 0)));
        for (int k = 0; k < n; k++) begin
            send_byte(frame_bytes[8*k +: 8]);
        end
        serial_tick(1'b1, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    endtask

    task automatic send_set(input logic [7:0] lvl, input logic [7:0] dfl, input logic [7:0] flip);
        logic [7:0] c;
        c = crc8_dow(crc8_dow(crc8_dow(8'h00, CMD_SET), lvl), dfl) ^ flip;
        if (flip == 8'h00) begin
            set_frames++;
        end else begin
            bad_frames++;
        end
        send_frame(4, {c, dfl, lvl, CMD_SET});
    endtask

    task automatic send_read();
        read_frames++;
        send_frame(4, {8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                       8'($urandom_range(255, 0)), CMD_READ});
    endtask

    // Drop the select after a few bits of a byte
    task automatic send_partial(input int nbits);
        odd_frames++;
        serial_tick(1'b0, 1'b1, 1'($urandom_range(1, 0)));
        repeat (nbits) begin
            serial_tick(1'b0, 1'b1, 1'($urandom_range(1, 0)));
            serial_tick(1'b0, 1'b0, 1'($urandom_range(1, 0)));
        end
        serial_tick(1'b1, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    endtask

    // Deselected ticks with random lamp, clock and data pins
    task automatic idle_pins(input int n);
        repeat (n) send_tick(1'($urandom_range(1, 0)), 1'b1, 1'($urandom_range(1, 0)),
                             1'($urandom_range(1, 0)));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (lamp_ticks_due.size() != 0);
    endtask

    // Write all three registers once the block has gone quiet
    task automatic set_config(input logic [15:0] t, input logic [7:0] h, input logic [9:0] p);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_wdata <= t;
        @(negedge aclk);
        cfg_index <= CFG_HOLD;
        cfg_wdata <= {8'd0, h};
        @(negedge aclk);
        cfg_index <= CFG_TPS;
        cfg_wdata <= {6'd0, p};
        @(negedge aclk);
        cfg_we      <= 1'b0;
        lim_seconds = t;
        lim_hold    = h;
        lim_tps     = p;
    endtask

    // Drive follows the level, holds after the request drops, then goes to zero
    task automatic test_lamp_hold();
        repeat (3) send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        repeat (23) send_tick(1'b1, 1'b1, 1'b1, 1'b1);
        set_config(RESET_TIMEOUT, 8'd0, RESET_TPS);
        repeat (2) send_tick(1'b0, 1'b1, 1'b0, 1'b1);
        repeat (2) send_tick(1'b1, 1'b1, 1'b1, 1'b0);
        set_config(RESET_TIMEOUT, 8'd255, RESET_TPS);
        repeat (2) send_tick(1'b0, 1'b1, 1'b1, 1'b0);
        repeat (4) send_tick(1'b1, 1'b1, 1'b0, 1'b1);
    endtask

    // Set, bad CRC, read-back, unknown command and a byte cut short by deselect
    task automatic test_commands();
        lamp_off_now  = 1'b0;
        lamp_flip_pct = 0;
        send_set(8'h00, 8'hFF, 8'h00);
        send_set(8'h37, 8'h12, 8'h01);
        send_read();
        odd_frames++;
        send_frame(1, {24'd0, BOGUS_CMD});
        send_partial(3);
    endtask

    // Fallback to default: every tick, zero limits, set clearing seconds, lowered limit
    task automatic test_timeout();
        set_config(16'd1, 8'd20, 10'd1);
        send_set(8'hC8, 8'h64, 8'h00);
        idle_pins(3);
        set_config(16'd0, 8'd20, 10'd0);
        idle_pins(3);
        set_config(16'd2, 8'd20, 10'd3);
        send_set(8'h11, 8'h64, 8'h00);
        idle_pins(8);
        set_config(16'hFFFF, 8'd20, 10'd1023);
        idle_pins(12);
        set_config(16'hFFFF, 8'd20, 10'd4);
        idle_pins(3);
    endtask

    // Hold off the result side long enough to fill the block, then drain fully
    task automatic test_backpressure();
        rx_hold_req = 60;
        repeat (30) send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                              1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        wait_drained();
    endtask

    // Mostly well-formed frames with random content, the rest noise and broken frames
    task automatic test_random();
        int         start;
        int         pick;
        logic [7:0] lvl;
        logic [7:0] dfl;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_en = (ph != 0);
            if (ph == 0) begin
                set_config(16'($urandom_range(3, 1)), 8'($urandom_range(8, 0)),
                           10'($urandom_range(6, 1)));
            end else begin
                pick = $urandom_range(9, 0);
                set_config((pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0
                               : 16'($urandom_range(4, 1)),
                           (pick == 2) ? 8'd255 : (pick == 3) ? 8'd0
                               : 8'($urandom_range(30, 0)),
                           (pick == 4) ? 10'd1023 : 10'($urandom_range(8, 1)));
            end
            lamp_flip_pct = 4;
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                pick = $urandom_range(99, 0);
                lvl  = 8'($urandom_range(255, 0));
                dfl  = ($urandom_range(99, 0) < 40) ? dflt_lvl : 8'($urandom_range(255, 0));
                if (pick < 45) begin
                    send_set(lvl, dfl, 8'h00);
                end else if (pick < 55) begin
                    send_set(lvl, dfl, 8'($urandom_range(255, 1)));
                end else if (pick < 70) begin
                    send_read();
                end else if (pick < 78) begin
                    send_partial(int'($urandom_range(7, 1)));
                end else if (pick < 84) begin
                    odd_frames++;
                    send_frame(int'($urandom_range(4, 1)), $urandom);
                end else begin
                    repeat ($urandom_range(12, 1)) begin
                        send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                                  1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                    end
                end
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_TIMEOUT;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_lamp_off_pin = 1'b1;
        s_select_pin   = 1'b1;
        s_clock_pin    = 1'b0;
        s_data_pin     = 1'b0;
        idle_en        = 1'b1;
        lamp_off_now   = 1'b0;
        lamp_flip_pct  = 0;
        rx_hold_req    = 0;

        // predictor after reset
        lim_seconds = RESET_TIMEOUT;
        lim_hold    = RESET_HOLD;
        lim_tps     = RESET_TPS;
        cur_lvl     = RESET_LEVEL;
        dflt_lvl    = RESET_LEVEL;
        hold_cnt    = 8'd0;
        drive_lvl   = 8'd0;
        tick_cnt    = 10'd0;
        sec_cnt     = 16'd0;
        sel_on      = 1'b0;
        sclk_high   = 1'b0;
        bits_to_go  = 4'd0;
        shreg       = 8'h00;
        cmd_phase   = PH_IDLE;
        crc_acc     = 8'h00;
        new_lvl     = 8'h00;
        new_dflt    = 8'h00;
        miso_q      = 1'b0;

        // hold reset, then release it at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_lamp_hold();
        test_commands();
        test_timeout();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("Run covered %0d ticks: %0d good sets, %0d bad-CRC sets, %0d read-backs,",
                 ticks_sent, set_frames, bad_frames, read_frames);
        $display("%0d cut or unknown frames; %0d levels applied, %0d default changes,",
                 odd_frames, sets_applied, dflt_changes);
        $display("%0d fallbacks to the default level.", reverts);
        if (errors == 0) begin
            $display("tb_lamp_brightness_spi_command_slave_unit: done, clean");
        end else begin
            $display("tb_lamp_brightness_spi_command_slave_unit: done, errors");
        end
        $finish;
    end

endmodule
